// ===== hw/rtl/cppb_pkg.sv =====
// ----------------------------------------------------------------------------
// cppb_pkg: shared definitions for the coverage pixel plot/blend canvas
// Operation codes, register indexes, blend constants and default sizes.
// ----------------------------------------------------------------------------
package cppb_pkg;

  // default canvas store dimensions
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 256;

  // operation codes carried in tuser
  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_PLOT      = 2'd1;
  localparam logic [1:0] OP_COMPOSITE = 2'd2;

  // configuration register indexes
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  // configuration reset values
  localparam logic [9:0] RST_CANVAS_WIDTH  = 10'd372;
  localparam logic [8:0] RST_CANVAS_HEIGHT = 9'd76;

  // blend constants
  localparam logic [7:0] OPAQUE_LEVEL = 8'd250;
  localparam logic [7:0] FULL_COV     = 8'd255;
  localparam logic [8:0] UNITY        = 9'd256;
  localparam int         CH_W         = 5;

endpackage

// ===== hw/rtl/cppb_mix.sv =====
// ----------------------------------------------------------------------------
// cppb_mix: RGBA5551 channel blend
// Blends fg over bg per 5-bit channel with weight a in 0..256 and sets alpha.
// ----------------------------------------------------------------------------
module cppb_mix
  import cppb_pkg::*;
(
  input  logic [15:0] fg,
  input  logic [15:0] bg,
  input  logic [8:0]  weight,
  output logic [15:0] blended
);

  logic [8:0] inv_weight;

  assign inv_weight = UNITY - weight;

  // weigh each channel: R at 15..11, G at 10..6, B at 5..1
  always_comb begin
    logic [13:0] fg_term;
    logic [13:0] bg_term;
    logic [13:0] sum;
    int          lsb;
    blended = '0;
    blended[0] = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lsb     = 11 - CH_W * i;
      fg_term = 14'(fg[lsb +: CH_W]) * 14'(weight);
      bg_term = 14'(bg[lsb +: CH_W]) * 14'(inv_weight);
      sum     = fg_term + bg_term;
      blended[lsb +: CH_W] = sum[8 +: CH_W];
    end
  end

endmodule

// ===== hw/rtl/coverage_pixel_plot_blend.sv =====
// ----------------------------------------------------------------------------
// coverage_pixel_plot_blend: overlay canvas with plot and composite
// One pixel store (color, coverage, opacity) read, modified and written back.
//
//   channel | direction | payload
//   s_*     | in        | tuser: op; tdata: x, y, color, cov, pen, fade, bg
//   m_*     | out       | tdata: out_pixel, out_opacity
//   cfg_*   | in        | canvas_width (0), canvas_height (1)
//
// An item passes through accept, address multiply, store read, weight
// multiply, blend and write back. One item is in flight at a time.
// A composite result waits in the output register; the next item is
// accepted meanwhile and stalls in its blend step only if the register is full.
// Reset clears control and config; the pixel store is not cleared.
// ----------------------------------------------------------------------------
module coverage_pixel_plot_blend
  import cppb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [10:0] pos_x, [21:11] pos_y, [37:22] draw_color, [45:38] coverage,
  // [53:46] pen_opacity, [62:54] fade_alpha, [78:63] bg_pixel, [79] zero
  input  logic [79:0] s_tdata,
  // [1:0] op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] out_pixel, [23:16] out_opacity
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [10:0] MAX_W = 11'(MAX_WIDTH);
  localparam logic [10:0] MAX_H = 11'(MAX_HEIGHT);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADDR = 5'b00010,
    ST_READ = 5'b00100,
    ST_CALC = 5'b01000,
    ST_MIX  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [7:0]  opacity;
    logic [7:0]  cov;
    logic [15:0] color;
  } entry_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [9:0] canvas_width;
  logic [8:0] canvas_height;

  // captured request
  logic [1:0]  item_op;
  logic [10:0] item_x;
  logic [10:0] item_y;
  logic [15:0] item_color;
  logic [7:0]  item_cov;
  logic [7:0]  item_pen;
  logic [8:0]  item_fade;
  logic [15:0] item_bg;

  // address stage
  logic [10:0]      w_sat;
  logic [10:0]      h_sat;
  logic [20:0]      idx_sum;
  logic             in_canvas_next;
  logic             in_canvas;
  logic [IDX_W-1:0] idx;

  // store
  entry_t mem [DEPTH];
  entry_t rd;
  entry_t wdata;
  logic   mem_we;

  // plan registers and their next values
  logic        wr_en, wr_en_next;
  logic        wr_mix, wr_mix_next;
  logic [15:0] wr_color, wr_color_next;
  logic [7:0]  wr_cov, wr_cov_next;
  logic [7:0]  wr_opa, wr_opa_next;
  logic        res_en, res_en_next;
  logic        res_mix, res_mix_next;
  logic [15:0] res_pixel, res_pixel_next;
  logic [7:0]  res_opa, res_opa_next;
  logic [15:0] mix_fg, mix_fg_next;
  logic [15:0] mix_bg, mix_bg_next;
  logic [8:0]  mix_a, mix_a_next;

  logic [15:0] mixed;
  logic        out_free;
  logic        leave_mix;

  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign leave_mix = (state == ST_MIX) && (!res_en || out_free);
  assign mem_we    = leave_mix && wr_en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= RST_CANVAS_WIDTH;
      canvas_height <= RST_CANVAS_HEIGHT;
    end else if (cfg_we) begin
      if (cfg_index == REG_CANVAS_WIDTH) begin
        canvas_width <= cfg_data;
      end
      if (cfg_index == REG_CANVAS_HEIGHT) begin
        canvas_height <= cfg_data[8:0];
      end
    end
  end

  // sequence one request through the stages
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_ADDR;
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: state_next = ST_CALC;
      ST_CALC: state_next = ST_MIX;
      ST_MIX: begin
        if (leave_mix) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op    <= s_tuser;
      item_x     <= s_tdata[10:0];
      item_y     <= s_tdata[21:11];
      item_color <= s_tdata[37:22];
      item_cov   <= s_tdata[45:38];
      item_pen   <= s_tdata[53:46];
      item_fade  <= s_tdata[62:54];
      item_bg    <= s_tdata[78:63];
    end
  end

  // clip to the saturated canvas and form the row-major index
  always_comb begin
    w_sat = ({1'b0, canvas_width} > MAX_W) ? MAX_W : {1'b0, canvas_width};
    h_sat = ({2'b0, canvas_height} > MAX_H) ? MAX_H : {2'b0, canvas_height};
    in_canvas_next = !item_x[10] && !item_y[10] &&
                     ({1'b0, item_x[9:0]} < w_sat) && ({1'b0, item_y[9:0]} < h_sat);
    idx_sum = 21'(item_y[9:0]) * 21'(w_sat) + 21'(item_x[9:0]);
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      in_canvas <= in_canvas_next;
      idx       <= idx_sum[IDX_W-1:0];
    end
  end

  // pixel store: registered read, write back on leaving the blend step
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wdata;
    end
    if (state == ST_READ) begin
      rd <= mem[idx];
    end
  end

  // decide the update or the result from the stored entry
  always_comb begin
    logic [8:0]  fade_sat;
    logic [16:0] comp_prod;
    logic [8:0]  comp_a;
    logic [8:0]  plot_w;
    fade_sat  = (item_fade > UNITY) ? UNITY : item_fade;
    comp_prod = 17'(fade_sat) * 17'(rd.cov);
    comp_a    = comp_prod[16:8];
    plot_w    = {1'b0, item_cov} + {8'b0, item_cov[7]};

    wr_en_next     = 1'b0;
    wr_mix_next    = 1'b0;
    wr_color_next  = '0;
    wr_cov_next    = '0;
    wr_opa_next    = '0;
    res_en_next    = 1'b0;
    res_mix_next   = 1'b0;
    res_pixel_next = item_bg;
    res_opa_next   = '0;
    mix_fg_next    = item_color;
    mix_bg_next    = rd.color;
    mix_a_next     = plot_w;

    case (item_op)
      OP_CLEAR: begin
        wr_en_next = in_canvas;
      end
      OP_PLOT: begin
        wr_en_next = in_canvas && (item_cov != '0);
        if (item_cov == FULL_COV) begin
          wr_color_next = item_color;
          wr_cov_next   = FULL_COV;
          wr_opa_next   = item_pen;
        end else if (rd.cov >= OPAQUE_LEVEL) begin
          wr_mix_next = 1'b1;
          wr_cov_next = rd.cov;
          wr_opa_next = (item_pen > rd.opacity) ? item_pen : rd.opacity;
        end else begin
          wr_color_next = item_color;
          wr_cov_next   = (item_cov > rd.cov) ? item_cov : rd.cov;
          wr_opa_next   = item_pen;
        end
      end
      OP_COMPOSITE: begin
        res_en_next = 1'b1;
        if (in_canvas) begin
          res_opa_next = rd.opacity;
          res_mix_next = (comp_a != '0);
          mix_fg_next  = rd.color;
          mix_bg_next  = item_bg;
          mix_a_next   = comp_a;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      wr_en     <= wr_en_next;
      wr_mix    <= wr_mix_next;
      wr_color  <= wr_color_next;
      wr_cov    <= wr_cov_next;
      wr_opa    <= wr_opa_next;
      res_en    <= res_en_next;
      res_mix   <= res_mix_next;
      res_pixel <= res_pixel_next;
      res_opa   <= res_opa_next;
      mix_fg    <= mix_fg_next;
      mix_bg    <= mix_bg_next;
      mix_a     <= mix_a_next;
    end
  end

  // blend unit
  cppb_mix u_mix (
    .fg      (mix_fg),
    .bg      (mix_bg),
    .weight  (mix_a),
    .blended (mixed)
  );

  assign wdata = '{opacity: wr_opa, cov: wr_cov, color: (wr_mix ? mixed : wr_color)};

  // output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (leave_mix && res_en) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (leave_mix && res_en) begin
      m_tdata <= {res_opa, (res_mix ? mixed : res_pixel)};
    end
  end

endmodule

// ===== hw/rtl/cppb_checker.sv =====
// ----------------------------------------------------------------------------
// cppb_checker: port-level checks for the coverage pixel plot/blend canvas
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cppb_checker
  import cppb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one request in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // a fresh result follows an accepted request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
    else $error("result without matching request");

endmodule

bind coverage_pixel_plot_blend cppb_checker u_cppb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
